// ----- sv/cdq_pkg.sv -----
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH      = 128;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W      = $clog2(DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int WORD_W   = 32;
  localparam int FILL_W   = 8;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_ADD_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(DEPTH);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [OCC_W-1:0]      occ_t;

  function automatic idx_t step_up(input idx_t i);
    return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t step_down(input idx_t i);
    return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
  endfunction

endpackage

// ----- sv/cdq_ram.sv -----
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- sv/circular_deque_top.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: value; tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: data, fill_level; tuser: status
//
// adds and rejected operations show their result from the output register;
// removals pass through the ring memory's registered read port first.
// reset clears the indices, the count and the output valid flag; the ring
// itself is not cleared, only entries already written are ever read.
// input is held off after a removal while its word is fetched in S_READ,
// so adds run one beat a cycle unless the output stalls; removals are not overlapped.
// a stalled result stays in the output register and holds input off until taken.

module circular_deque_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cdq_pkg::S_DATA_W-1:0]    s_axis_tdata,  // [31:0] value
  input  logic [cdq_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cdq_pkg::M_DATA_W-1:0]    m_axis_tdata,  // [31:0] data, [39:32] fill_level
  output logic [cdq_pkg::STAT_W-1:0]      m_axis_tuser   // [1:0] status
);

  import cdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  idx_t front_q, front_d;
  idx_t back_q, back_d;
  occ_t occ_q, occ_d;

  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_data_q, out_data_d;
  logic [STAT_W-1:0]   out_stat_q, out_stat_d;
  logic [FILL_W-1:0]   out_fill_q, out_fill_d;
  logic [FILL_W-1:0]   pend_fill_q, pend_fill_d;

  logic   accept;
  logic   is_add;
  logic   ram_we, ram_re;
  idx_t   ram_waddr, ram_raddr;
  word_t  ram_wdata, ram_rdata;

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_add        = (s_axis_tuser == OP_ADD_FRONT) || (s_axis_tuser == OP_ADD_BACK);
  assign ram_wdata     = word_t'(s_axis_tdata);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_stat_d  = out_stat_q;
    out_fill_d  = out_fill_q;
    pend_fill_d = pend_fill_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = back_q;
    ram_raddr   = front_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_add) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            if (occ_q >= OCC_FULL) begin
              out_stat_d = STAT_OVERFLOW;
              out_fill_d = FILL_W'(occ_q);
            end else begin
              ram_we     = 1'b1;
              occ_d      = occ_t'(occ_q + 1'b1);
              out_stat_d = STAT_OK;
              out_fill_d = FILL_W'(occ_d);
              if (s_axis_tuser == OP_ADD_FRONT) begin
                front_d   = step_down(front_q);
                ram_waddr = front_d;
              end else begin
                ram_waddr = back_q;
                back_d    = step_up(back_q);
              end
            end
          end else if (occ_q == '0) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            out_stat_d  = STAT_UNDERFLOW;
            out_fill_d  = FILL_W'(occ_q);
          end else begin
            // word comes back next cycle, when S_READ loads it into the output register
            ram_re      = 1'b1;
            occ_d       = occ_t'(occ_q - 1'b1);
            pend_fill_d = FILL_W'(occ_d);
            state_d     = S_READ;
            if (s_axis_tuser == OP_REM_FRONT) begin
              ram_raddr = front_q;
              front_d   = step_up(front_q);
            end else begin
              back_d    = step_down(back_q);
              ram_raddr = back_d;
            end
          end
        end
      end
      S_READ: begin
        // output register is free here: it was free or draining at accept
        out_valid_d = 1'b1;
        out_data_d  = WORD_W'(ram_rdata);
        out_stat_d  = STAT_OK;
        out_fill_d  = pend_fill_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_stat_q  <= out_stat_d;
    out_fill_q  <= out_fill_d;
    pend_fill_q <= pend_fill_d;
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_fill_q, out_data_q};
  assign m_axis_tuser  = out_stat_q;

endmodule

// ----- sv/cdq_checker.sv -----
`timescale 1ns / 1ps

module cdq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cdq_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [cdq_pkg::STAT_W-1:0]   m_axis_tuser
);

  import cdq_pkg::*;

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result payload changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= STAT_UNDERFLOW)
    else $error("undefined status code");

  // a dropped add only happens on a full ring and returns no word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_OVERFLOW |->
      m_axis_tdata[31:0] == '0 && m_axis_tdata[39:32] == FILL_FULL)
    else $error("overflow result inconsistent");

  // an empty remove leaves the ring empty and returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_UNDERFLOW |-> m_axis_tdata == '0)
    else $error("underflow result inconsistent");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
